@@ src/rmd160_pkg.sv @@
// Shared types, constants and round tables for the RIPEMD-160 hash engine.
// No dependencies; the queue, front end, back end and top level import this package.
package rmd160_pkg;

   // Block buffer: two slots of sixteen words each
   localparam int WORD_W    = 32;
   localparam int BUF_DEPTH = 32;
   localparam int BUF_AW    = 5;

   // Command queue depth
   localparam int FIFO_DEPTH = 2;

   localparam logic [31:0] IV [5] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                      32'h10325476, 32'hc3d2e1f0};
   localparam logic [31:0] K_L [5] = '{32'h00000000, 32'h5a827999, 32'h6ed9eba1,
                                       32'h8f1bbcdc, 32'ha953fd4e};
   localparam logic [31:0] K_R [5] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3,
                                       32'h7a6d76e9, 32'h00000000};
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [3:0] SEL_L [80] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
      4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
      4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
      4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
      4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
      4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
      4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
      4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};
   localparam logic [3:0] SEL_R [80] = '{
      4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
      4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
      4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
      4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
      4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
      4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
      4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
      4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
      4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
      4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};
   localparam logic [3:0] ROT_L [80] = '{
      4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
      4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
      4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
      4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
      4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
      4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
      4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
      4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
      4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
      4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6};
   localparam logic [3:0] ROT_R [80] = '{
      4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
      4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
      4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
      4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
      4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
      4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
      4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
      4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
      4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
      4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11};

   // Compression command: which buffer slot, and whether it closes the message
   typedef struct packed {
      logic slot;
      logic last_blk;
   } cmd_type;

   // Slot handed back by the compression side
   typedef struct packed {
      logic valid;
      logic slot;
   } release_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [3:0] s);
      logic [5:0] rs;
      rs = 6'd32 - {2'b00, s};
      return (v << s) | (v >> rs);
   endfunction

   function automatic logic [31:0] boolfn(input logic [2:0] k, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
      logic [31:0] r;
      unique case (k)
         3'd0:    r = x ^ y ^ z;
         3'd1:    r = (x & y) | (~x & z);
         3'd2:    r = (x | ~y) ^ z;
         3'd3:    r = (x & z) | (y & ~z);
         default: r = x ^ (y | ~z);
      endcase
      return r;
   endfunction

endpackage

@@ src/rmd160_if.sv @@
// Valid/ready channel interfaces for message bytes and digest words.
// Depends on nothing.
interface rmd160_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_message;
   modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface rmd160_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ src/rmd160_ram.sv @@
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module rmd160_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end
endmodule

@@ src/rmd160_cmd_fifo.sv @@
// Two-entry queue of compression commands between front and back.
// Depends on rmd160_pkg.
module rmd160_cmd_fifo
   import rmd160_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);
   cmd_type    ent_ff [FIFO_DEPTH];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head  = ent_ff[rptr_ff];
   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);

   // Advance pointers and occupancy
   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         ent_ff[wptr_ff] <= push_cmd;
      end
   end
endmodule

@@ src/rmd160_front.sv @@
// Byte collector and padder: packs bytes into the block buffer, pads the
// final block(s) and queues compression commands. Depends on rmd160_pkg.
module rmd160_front
   import rmd160_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   rmd160_req_if.sink        req_ch,
   output logic              buf_we,
   output logic [BUF_AW-1:0] buf_waddr,
   output logic [31:0]       buf_wdata,
   output logic              cmd_push,
   output cmd_type           cmd_data,
   input  logic              cmd_full,
   input  release_type       rel
);
   localparam logic [1:0] ST_COLLECT = 2'd0;
   localparam logic [1:0] ST_PADHEAD = 2'd1;
   localparam logic [1:0] ST_PADFILL = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic        slot_ff, slot_in;
   logic [3:0]  wc_ff, wc_in;
   logic        two_ff, two_in;
   logic [1:0]  busy_ff, busy_in;

   logic        go;
   logic        take;
   logic [1:0]  k;
   logic [4:0]  sh;
   logic [31:0] keep_mask;
   logic [63:0] bits;

   assign go    = !busy_ff[slot_ff] && !cmd_full;
   assign req_ch.ready = (state_ff == ST_COLLECT) && go;
   assign take  = req_ch.valid && req_ch.ready;
   assign k     = fill_ff[1:0];
   assign sh    = {k, 3'b000};
   assign keep_mask = (32'h1 << sh) - 32'h1;
   assign bits  = {cnt_ff[60:0], 3'b000};

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      slot_in   = slot_ff;
      wc_in     = wc_ff;
      two_in    = two_ff;
      busy_in   = busy_ff;
      buf_we    = 1'b0;
      buf_waddr = {slot_ff, fill_ff[5:2]};
      buf_wdata = 32'h0;
      cmd_push  = 1'b0;
      cmd_data  = '{slot: slot_ff, last_blk: 1'b0};

      // Drop the busy mark of a slot the back end has finished with
      if (rel.valid) begin
         busy_in[rel.slot] = 1'b0;
      end

      unique case (state_ff)
         ST_COLLECT: begin
            if (take) begin
               if (req_ch.byte_valid) begin
                  // Pack the byte little-endian, clear the word at its first byte
                  acc_in = (k == 2'd0) ? {24'h0, req_ch.data_byte}
                                       : (acc_ff | ({24'h0, req_ch.data_byte} << sh));
                  buf_we    = (k == 2'd3);
                  buf_wdata = acc_in;
                  fill_in   = fill_ff + 6'd1;
                  cnt_in    = cnt_ff + 64'd1;
                  if (fill_ff == 6'd63) begin
                     cmd_push          = 1'b1;
                     busy_in[slot_ff]  = 1'b1;
                     slot_in           = ~slot_ff;
                  end
               end
               if (req_ch.end_of_message) begin
                  state_in = ST_PADHEAD;
               end
            end
         end
         ST_PADHEAD: begin
            // Write the partial word with the pad marker
            if (go) begin
               buf_we    = 1'b1;
               buf_wdata = (acc_ff & keep_mask) | ({24'h0, PAD_BYTE} << sh);
               two_in    = (fill_ff[5:3] == 3'b111) && (fill_ff[5:2] != 4'd15);
               state_in  = ST_PADFILL;
               if (fill_ff[5:2] == 4'd15) begin
                  cmd_push         = 1'b1;
                  busy_in[slot_ff] = 1'b1;
                  slot_in          = ~slot_ff;
                  wc_in            = 4'd0;
               end else begin
                  wc_in = fill_ff[5:2] + 4'd1;
               end
            end
         end
         ST_PADFILL: begin
            // Zero words, then the bit length in words 14 and 15 unless a second pad block follows
            if (go) begin
               buf_we    = 1'b1;
               buf_waddr = {slot_ff, wc_ff};
               if (!two_ff && wc_ff == 4'd14) begin
                  buf_wdata = bits[31:0];
               end else if (!two_ff && wc_ff == 4'd15) begin
                  buf_wdata = bits[63:32];
               end
               wc_in = wc_ff + 4'd1;
               if (wc_ff == 4'd15) begin
                  cmd_push          = 1'b1;
                  cmd_data.last_blk = !two_ff;
                  busy_in[slot_ff]  = 1'b1;
                  slot_in           = ~slot_ff;
                  two_in            = 1'b0;
                  if (!two_ff) begin
                     fill_in  = 6'd0;
                     cnt_in   = 64'd0;
                     state_in = ST_COLLECT;
                  end
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         fill_ff  <= 6'd0;
         cnt_ff   <= 64'd0;
         slot_ff  <= 1'b0;
         wc_ff    <= 4'd0;
         two_ff   <= 1'b0;
         busy_ff  <= 2'b00;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         slot_ff  <= slot_in;
         wc_ff    <= wc_in;
         two_ff   <= two_in;
         busy_ff  <= busy_in;
      end
      acc_ff <= acc_in;
   end
endmodule

@@ src/rmd160_back.sv @@
// Compression unit: one double round per cycle over a buffer slot, final
// cross-mix, and the digest words out. Depends on rmd160_pkg.
module rmd160_back
   import rmd160_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           head,
   input  logic              empty,
   output logic              pop,
   output logic [BUF_AW-1:0] raddr_a,
   output logic [BUF_AW-1:0] raddr_b,
   input  logic [31:0]       rdata_a,
   input  logic [31:0]       rdata_b,
   output release_type       rel,
   rmd160_rsp_if.source      rsp_ch
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_MIX  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic        slot_ff, slot_in;
   logic        last_ff, last_in;
   logic [2:0]  idx_ff, idx_in;
   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [31:0] lft_ff [5];
   logic [31:0] lft_in [5];
   logic [31:0] rgt_ff [5];
   logic [31:0] rgt_in [5];

   logic [6:0]  nxt;
   logic        rslot;
   logic [2:0]  grp;
   logic [31:0] tl, tr;

   // Read addresses run one round ahead of the datapath
   always_comb begin
      nxt     = (state_ff != ST_RUN || rnd_ff == 7'd79) ? 7'd0 : rnd_ff + 7'd1;
      rslot   = (state_ff == ST_IDLE) ? head.slot : slot_ff;
      raddr_a = {rslot, SEL_L[nxt]};
      raddr_b = {rslot, SEL_R[nxt]};
   end

   assign grp = rnd_ff[6:4];
   assign tl  = rotl32(lft_ff[0] + boolfn(grp, lft_ff[1], lft_ff[2], lft_ff[3])
                       + rdata_a + K_L[grp], ROT_L[rnd_ff]) + lft_ff[4];
   assign tr  = rotl32(rgt_ff[0] + boolfn(3'd4 - grp, rgt_ff[1], rgt_ff[2], rgt_ff[3])
                       + rdata_b + K_R[grp], ROT_R[rnd_ff]) + rgt_ff[4];

   assign rsp_ch.valid       = (state_ff == ST_OUT);
   assign rsp_ch.digest_word = chain_ff[idx_ff];
   assign rsp_ch.word_index  = idx_ff;
   assign rsp_ch.last_word   = (idx_ff == 3'd4);

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      slot_in  = slot_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      chain_in = chain_ff;
      lft_in   = lft_ff;
      rgt_in   = rgt_ff;
      pop      = 1'b0;
      rel      = '{valid: 1'b0, slot: slot_ff};

      unique case (state_ff)
         ST_IDLE: begin
            // Take the next command and load both lines from the chain
            if (!empty) begin
               pop      = 1'b1;
               slot_in  = head.slot;
               last_in  = head.last_blk;
               rnd_in   = 7'd0;
               lft_in   = chain_ff;
               rgt_in   = chain_ff;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            lft_in[0] = lft_ff[4];
            lft_in[4] = lft_ff[3];
            lft_in[3] = rotl32(lft_ff[2], 4'd10);
            lft_in[2] = lft_ff[1];
            lft_in[1] = tl;
            rgt_in[0] = rgt_ff[4];
            rgt_in[4] = rgt_ff[3];
            rgt_in[3] = rotl32(rgt_ff[2], 4'd10);
            rgt_in[2] = rgt_ff[1];
            rgt_in[1] = tr;
            rnd_in    = rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            // Cross-mix into the chain and hand the slot back
            chain_in[1] = chain_ff[2] + lft_ff[3] + rgt_ff[4];
            chain_in[2] = chain_ff[3] + lft_ff[4] + rgt_ff[0];
            chain_in[3] = chain_ff[4] + lft_ff[0] + rgt_ff[1];
            chain_in[4] = chain_ff[0] + lft_ff[1] + rgt_ff[2];
            chain_in[0] = chain_ff[1] + lft_ff[2] + rgt_ff[3];
            rel.valid   = 1'b1;
            idx_in      = 3'd0;
            state_in    = last_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            // Hold each word until taken; restore the chain after the fifth
            if (rsp_ch.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  idx_in   = 3'd0;
                  chain_in = IV;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 3'd0;
         chain_ff <= IV;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
      end
      rnd_ff  <= rnd_in;
      slot_ff <= slot_in;
      last_ff <= last_in;
      lft_ff  <= lft_in;
      rgt_ff  <= rgt_in;
   end
endmodule

@@ src/ripemd160_hash_engine.sv @@
// RIPEMD-160 engine: one byte per transaction while a buffer slot is free and the queue has room.
// A 64-byte block compresses in a load, 80 double rounds and a final
// mix on the single round unit; two buffer slots let collection overlap it.
// A finishing transaction pads into one or two blocks; once they compress,
// the digest words follow, one per cycle while taken.
// Synchronous reset restores the initial chain, empties the queue and marks both buffer slots free.
module ripemd160_hash_engine
   import rmd160_pkg::*;
(
   input logic          clock,
   input logic          reset,
   rmd160_req_if.sink   req_ch,
   rmd160_rsp_if.source rsp_ch
);
   logic              buf_we;
   logic [BUF_AW-1:0] buf_waddr, raddr_a, raddr_b;
   logic [31:0]       buf_wdata, rdata_a, rdata_b;
   logic              cmd_push, cmd_pop, cmd_empty, cmd_full;
   cmd_type           cmd_data, cmd_head;
   release_type       rel;

   rmd160_front u_front (
      .clock, .reset, .req_ch,
      .buf_we, .buf_waddr, .buf_wdata,
      .cmd_push, .cmd_data, .cmd_full, .rel
   );

   rmd160_cmd_fifo u_fifo (
      .clock, .reset,
      .push(cmd_push), .push_cmd(cmd_data), .pop(cmd_pop),
      .head(cmd_head), .empty(cmd_empty), .full(cmd_full)
   );

   rmd160_ram #(.WIDTH(WORD_W), .DEPTH(BUF_DEPTH)) u_buf (
      .clock, .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
      .raddr_a, .raddr_b, .rdata_a, .rdata_b
   );

   rmd160_back u_back (
      .clock, .reset,
      .head(cmd_head), .empty(cmd_empty), .pop(cmd_pop),
      .raddr_a, .raddr_b, .rdata_a, .rdata_b, .rel, .rsp_ch
   );
endmodule

@@ src/rmd160_checker.sv @@
// Port-level checks on the digest channel, bound to the engine's top level.
// Depends on the engine's interface ports only.
module rmd160_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_word,
   input logic [2:0]  rsp_index,
   input logic        rsp_last
);
   // Last flag marks exactly the fifth word
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_index == 3'd4)))
      else $error("last_word disagrees with word_index");

   // Index stays within the digest
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_index <= 3'd4))
      else $error("word_index out of range");

   // Words of one digest follow back to back in order
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_index == $past(rsp_index) + 3'd1))
      else $error("digest words not contiguous");

   // Stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("digest word dropped or changed under stall");
endmodule

bind ripemd160_hash_engine rmd160_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_word(rsp_ch.digest_word), .rsp_index(rsp_ch.word_index),
   .rsp_last(rsp_ch.last_word)
);
